// ----- sv/ule_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ule_pkg
// Shared types and constants of the UTF-8 line edit buffer.
// ----------------------------------------------------------------------------
package ule_pkg;

  // Width of the byte limit register and of the fit arithmetic
  localparam int unsigned LimitW = 9;

  // Reset value of the byte limit register
  localparam logic [LimitW-1:0] LimitReset = 9'd256;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } ule_op_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_DEL_CHECK,
    ST_READ_WAIT,
    ST_DONE
  } ule_state_e;

  // UTF-8 lead and continuation markers
  localparam logic [1:0] ContMark = 2'b10;
  localparam logic [2:0] Lead2    = 3'b110;
  localparam logic [3:0] Lead3    = 4'b1110;
  localparam logic [4:0] Lead4    = 5'b11110;

  // Length thresholds of the encoding
  localparam logic [20:0] Limit1 = 21'h00080;
  localparam logic [20:0] Limit2 = 21'h00800;
  localparam logic [20:0] Limit3 = 21'h10000;

  // One encoded code point: length and up to four bytes, lead first
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } ule_enc_t;

  // Request from the sequencer to the byte store
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [7:0] wdata;
  } ule_mem_req_t;

endpackage : ule_pkg
`default_nettype wire

// ----- sv/utf8_line_edit_buffer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_line_edit_buffer
// Text entry line held as UTF-8 bytes with fill and character counters.
// ----------------------------------------------------------------------------
// One word at a time goes through a sequencer around a single-port byte
// store with registered read data. An append that is stored passes through
// ST_APPEND, one store write per encoded byte, then ST_DONE for the result
// load; a rejected append, a zero code point, a delete on an empty line or
// an unused opcode goes straight to ST_DONE; a read passes ST_READ_WAIT and
// a delete ST_DEL_CHECK, one store read per byte scanned back (1 to 4 for
// well-formed text), each then ST_DONE. The result word sits in an output
// register, so the next word is taken while it waits. The byte store is not
// cleared after reset; only bytes below the fill ever reach a result word.
// ----------------------------------------------------------------------------
module utf8_line_edit_buffer #(
  parameter int unsigned STORE_BYTES = 256
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // configuration
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire  [ule_pkg::LimitW-1:0]   cfg_data_i,
  // input words
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [1:0]                   in_opcode_i,
  input  wire  [20:0]                  in_code_point_i,
  input  wire  [7:0]                   in_read_index_i,
  // result words
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         out_accepted_o,
  output logic [2:0]                   out_bytes_added_o,
  output logic [7:0]                   out_read_byte_o,
  output logic [7:0]                   out_byte_count_o,
  output logic [7:0]                   out_char_count_o
);
  import ule_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  logic [LimitW-1:0] limit_q;
  ule_mem_req_t      mem_req;
  logic [AW-1:0]     mem_addr;
  logic [7:0]        mem_rdata;

  // Byte limit register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  ule_ctrl #(
    .STORE_BYTES (STORE_BYTES),
    .AW          (AW)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .limit_i           (limit_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_opcode_i       (in_opcode_i),
    .in_code_point_i   (in_code_point_i),
    .in_read_index_i   (in_read_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_accepted_o    (out_accepted_o),
    .out_bytes_added_o (out_bytes_added_o),
    .out_read_byte_o   (out_read_byte_o),
    .out_byte_count_o  (out_byte_count_o),
    .out_char_count_o  (out_char_count_o),
    .mem_req_o         (mem_req),
    .mem_addr_o        (mem_addr),
    .mem_rdata_i       (mem_rdata)
  );

  ule_byte_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .addr_i  (mem_addr),
    .rdata_o (mem_rdata)
  );

endmodule : utf8_line_edit_buffer
`default_nettype wire

// ----- sv/ule_byte_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ule_byte_ram
// Single-port byte store with registered read data.
// ----------------------------------------------------------------------------
module ule_byte_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire                        clk_i,
  input  wire ule_pkg::ule_mem_req_t req_i,
  input  wire  [AW-1:0]              addr_i,
  output logic [7:0]                 rdata_o
);
  import ule_pkg::*;

  logic [7:0] mem [DEPTH];

  // Write on request, register the read word
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[addr_i] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule : ule_byte_ram
`default_nettype wire

// ----- sv/ule_utf8_enc.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ule_utf8_enc
// Encodes one code point into 1 to 4 UTF-8 bytes by the length rule.
// ----------------------------------------------------------------------------
module ule_utf8_enc (
  input  wire  [20:0]         cp_i,
  output ule_pkg::ule_enc_t   enc_o
);
  import ule_pkg::*;

  // Pick length by range; no check on surrogates or out-of-range values
  always_comb begin
    enc_o.bytes = '0;
    priority if (cp_i < Limit1) begin
      enc_o.len      = 3'd1;
      enc_o.bytes[0] = cp_i[7:0];
    end else if (cp_i < Limit2) begin
      enc_o.len      = 3'd2;
      enc_o.bytes[0] = {Lead2, cp_i[10:6]};
      enc_o.bytes[1] = {ContMark, cp_i[5:0]};
    end else if (cp_i < Limit3) begin
      enc_o.len      = 3'd3;
      enc_o.bytes[0] = {Lead3, cp_i[15:12]};
      enc_o.bytes[1] = {ContMark, cp_i[11:6]};
      enc_o.bytes[2] = {ContMark, cp_i[5:0]};
    end else begin
      enc_o.len      = 3'd4;
      enc_o.bytes[0] = {Lead4, cp_i[20:18]};
      enc_o.bytes[1] = {ContMark, cp_i[17:12]};
      enc_o.bytes[2] = {ContMark, cp_i[11:6]};
      enc_o.bytes[3] = {ContMark, cp_i[5:0]};
    end
  end

endmodule : ule_utf8_enc
`default_nettype wire

// ----- sv/ule_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ule_ctrl
// Item sequencer: fit check, byte writes, backward delete scan, byte reads,
// fill and character counters and the result register.
// ----------------------------------------------------------------------------
module ule_ctrl #(
  parameter int unsigned STORE_BYTES = 256,
  parameter int unsigned AW          = 8
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [ule_pkg::LimitW-1:0]   limit_i,
  // input words
  input  wire                          in_valid_i,
  output logic                         in_stall_o,
  input  wire  [1:0]                   in_opcode_i,
  input  wire  [20:0]                  in_code_point_i,
  input  wire  [7:0]                   in_read_index_i,
  // result words
  output logic                         out_valid_o,
  input  wire                          out_stall_i,
  output logic                         out_accepted_o,
  output logic [2:0]                   out_bytes_added_o,
  output logic [7:0]                   out_read_byte_o,
  output logic [7:0]                   out_byte_count_o,
  output logic [7:0]                   out_char_count_o,
  // byte store
  output ule_pkg::ule_mem_req_t        mem_req_o,
  output logic [AW-1:0]                mem_addr_o,
  input  wire  [7:0]                   mem_rdata_i
);
  import ule_pkg::*;

  localparam int unsigned Cap = (STORE_BYTES < 256) ? STORE_BYTES : 256;

  // Map a 9-bit byte position onto the store address
  function automatic logic [AW-1:0] to_addr(input logic [LimitW-1:0] pos);
    logic [AW+LimitW-1:0] wide;
    wide = {{AW{1'b0}}, pos};
    return wide[AW-1:0];
  endfunction

  ule_state_e  state_q, state_d;
  ule_enc_t    enc_in, enc_q, enc_d;
  logic [7:0]  idx_q, idx_d;
  logic [1:0]  k_q, k_d;
  logic [7:0]  p_q, p_d;
  logic [7:0]  fill_q, fill_d;
  logic [7:0]  chars_q, chars_d;
  logic        acc_q, acc_d;
  logic [2:0]  added_q, added_d;
  logic [7:0]  rdb_q, rdb_d;
  logic        out_valid_q, out_valid_d;
  logic        out_acc_q;
  logic [2:0]  out_added_q;
  logic [7:0]  out_rdb_q, out_fill_q, out_chars_q;

  logic              in_accept;
  logic              load;
  logic              fits;
  logic              last_byte;
  logic              is_cont;
  logic [LimitW-1:0] lim;
  logic [LimitW-1:0] fill9;
  ule_op_e           op_in;

  ule_utf8_enc u_enc (
    .cp_i  (in_code_point_i),
    .enc_o (enc_in)
  );

  // Decode handshake and shared conditions
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load       = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign op_in      = ule_op_e'(in_opcode_i);
  assign fill9      = {1'b0, fill_q};
  assign lim        = (limit_i > LimitW'(Cap)) ? LimitW'(Cap) : limit_i;
  assign fits       = (fill9 + LimitW'(enc_in.len)) < lim;
  assign last_byte  = ({1'b0, k_q} == (enc_q.len - 3'd1));
  assign is_cont    = (mem_rdata_i[7:6] == ContMark);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (op_in)
            OP_APPEND: state_d = (fits && (in_code_point_i != '0)) ? ST_APPEND : ST_DONE;
            OP_DELETE: state_d = (fill_q != '0) ? ST_DEL_CHECK : ST_DONE;
            OP_READ:   state_d = ST_READ_WAIT;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_APPEND:    if (last_byte) state_d = ST_DONE;
      ST_DEL_CHECK: if (!is_cont || (p_q == 8'd1)) state_d = ST_DONE;
      ST_READ_WAIT: state_d = ST_DONE;
      ST_DONE:      if (load) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Datapath and store requests
  always_comb begin
    enc_d           = enc_q;
    idx_d           = idx_q;
    k_d             = k_q;
    p_d             = p_q;
    fill_d          = fill_q;
    chars_d         = chars_q;
    acc_d           = acc_q;
    added_d         = added_q;
    rdb_d           = rdb_q;
    mem_req_o       = '0;
    mem_addr_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          acc_d   = 1'b0;
          added_d = '0;
          rdb_d   = '0;
          k_d     = '0;
          p_d     = fill_q;
          idx_d   = in_read_index_i;
          enc_d   = enc_in;
          unique case (op_in)
            OP_APPEND: acc_d = fits;
            OP_DELETE: begin
              // fetch the last byte ahead of the scan
              mem_req_o.rd_en = (fill_q != '0);
              mem_addr_o      = to_addr(fill9 - 9'd1);
            end
            OP_READ: begin
              mem_req_o.rd_en = 1'b1;
              mem_addr_o      = to_addr({1'b0, in_read_index_i});
            end
            default: ;
          endcase
        end
      end
      ST_APPEND: begin
        // write one encoded byte per cycle, commit counts on the last
        mem_req_o.wr_en = 1'b1;
        mem_req_o.wdata = enc_q.bytes[k_q];
        mem_addr_o      = to_addr(fill9 + {7'd0, k_q});
        k_d             = k_q + 2'd1;
        if (last_byte) begin
          fill_d  = 8'(fill9 + LimitW'(enc_q.len));
          chars_d = chars_q + 8'd1;
          added_d = enc_q.len;
        end
      end
      ST_DEL_CHECK: begin
        if (is_cont) begin
          // drop the continuation byte and fetch the one before it
          p_d = p_q - 8'd1;
          if (p_q == 8'd1) begin
            fill_d = '0;
          end else begin
            mem_req_o.rd_en = 1'b1;
            mem_addr_o      = to_addr({1'b0, p_q - 8'd2});
          end
        end else begin
          fill_d  = p_q - 8'd1;
          chars_d = (chars_q != '0) ? (chars_q - 8'd1) : '0;
          acc_d   = 1'b1;
        end
      end
      ST_READ_WAIT: begin
        rdb_d = (idx_q < fill_q) ? mem_rdata_i : '0;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // Hold the result word until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      chars_q     <= chars_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    enc_q   <= enc_d;
    idx_q   <= idx_d;
    k_q     <= k_d;
    p_q     <= p_d;
    acc_q   <= acc_d;
    added_q <= added_d;
    rdb_q   <= rdb_d;
    if (load) begin
      out_acc_q   <= acc_q;
      out_added_q <= added_q;
      out_rdb_q   <= rdb_q;
      out_fill_q  <= fill_q;
      out_chars_q <= chars_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_accepted_o    = out_acc_q;
  assign out_bytes_added_o = out_added_q;
  assign out_read_byte_o   = out_rdb_q;
  assign out_byte_count_o  = out_fill_q;
  assign out_char_count_o  = out_chars_q;

endmodule : ule_ctrl
`default_nettype wire

// ----- sv/ule_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ule_checker
// Port-level checks of the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module ule_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_stall_o,
  input wire       out_valid_o,
  input wire       out_stall_i,
  input wire       out_accepted_o,
  input wire [2:0] out_bytes_added_o,
  input wire [7:0] out_read_byte_o
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // Take one word at a time: stall after an accepted word
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the item finished");

  // Stored bytes only come with an accepted append
  a_added_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_bytes_added_o != 3'd0) |-> out_accepted_o)
    else $error("bytes added without acceptance");

  // A read byte appears only on a read result
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_read_byte_o != 8'd0)
      |-> !out_accepted_o && (out_bytes_added_o == 3'd0))
    else $error("read byte on a non-read result");

endmodule : ule_checker

bind utf8_line_edit_buffer ule_checker u_ule_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_accepted_o    (out_accepted_o),
  .out_bytes_added_o (out_bytes_added_o),
  .out_read_byte_o   (out_read_byte_o)
);
`default_nettype wire

// ----- bench/utf8_line_edit_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_line_edit_checker
// Watches the channels of the UTF-8 line edit buffer and scores its results.
// ----------------------------------------------------------------------------
// Keeps its own copy of the line (bytes, fill and character count) and of the
// byte limit. Every word taken by the block is turned into the result it must
// give; every result word leaving the block is compared field by field with
// the oldest of those. The number of failures and of results still due are
// handed to the bench top.
// ----------------------------------------------------------------------------
module utf8_line_edit_checker
  import ule_pkg::*;
#(
  parameter int unsigned STORE_BYTES = 256
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  // configuration channel
  input  wire              cfg_valid_i,
  input  wire              cfg_ready_i,
  input  wire [LimitW-1:0] cfg_data_i,
  // input words
  input  wire              in_valid_i,
  input  wire              in_stall_i,
  input  wire [1:0]        in_opcode_i,
  input  wire [20:0]       in_code_point_i,
  input  wire [7:0]        in_read_index_i,
  // result words
  input  wire              out_valid_i,
  input  wire              out_stall_i,
  input  wire              out_accepted_i,
  input  wire [2:0]        out_bytes_added_i,
  input  wire [7:0]        out_read_byte_i,
  input  wire [7:0]        out_byte_count_i,
  input  wire [7:0]        out_char_count_i,
  // status towards the bench top
  output int unsigned      fail_count_o,
  output int unsigned      results_due_o
);

  // One result word of the block
  typedef struct packed {
    logic       accepted;
    logic [2:0] bytes_added;
    logic [7:0] read_byte;
    logic [7:0] byte_count;
    logic [7:0] char_count;
  } edit_result_t;

  // Mirror of the line and of the byte limit
  logic [7:0]        line_bytes [STORE_BYTES];
  int unsigned       line_fill;
  int unsigned       line_chars;
  logic [LimitW-1:0] byte_limit;

  edit_result_t      due_results [$];
  edit_result_t      oldest_due;
  int unsigned       errors = 0;

  assign fail_count_o = errors;

  // Apply one word to the mirrored line and return the result it must give
  function automatic edit_result_t edit_line(input logic [1:0] op, input logic [20:0] cp,
                                             input logic [7:0] idx);
    edit_result_t    res;
    logic [3:0][7:0] enc;
    int unsigned     len;
    int unsigned     cap;
    res = '0;
    enc = '0;
    cap = 32'(byte_limit);
    if (cap > STORE_BYTES) cap = STORE_BYTES;
    if (cap > 256) cap = 256;
    case (op)
      OP_APPEND: begin
        // encode by the length rule alone, surrogates and all
        if (cp < Limit1) begin
          len = 1;
          enc[0] = cp[7:0];
        end else if (cp < Limit2) begin
          len = 2;
          enc[0] = {Lead2, cp[10:6]};
          enc[1] = {ContMark, cp[5:0]};
        end else if (cp < Limit3) begin
          len = 3;
          enc[0] = {Lead3, cp[15:12]};
          enc[1] = {ContMark, cp[11:6]};
          enc[2] = {ContMark, cp[5:0]};
        end else begin
          len = 4;
          enc[0] = {Lead4, cp[20:18]};
          enc[1] = {ContMark, cp[17:12]};
          enc[2] = {ContMark, cp[11:6]};
          enc[3] = {ContMark, cp[5:0]};
        end
        // keep one position free for the terminator
        if (line_fill + len < cap) begin
          res.accepted = 1'b1;
          if (cp != '0) begin
            for (int i = 0; i < len; i++) line_bytes[8'(line_fill + i)] = enc[i];
            line_fill += len;
            line_chars = (line_chars + 1) & 32'hFF;
            res.bytes_added = len[2:0];
          end
        end
      end
      OP_DELETE: begin
        // drop trailing continuation bytes, then the lead
        while (line_fill > 0 && line_bytes[8'(line_fill - 1)][7:6] == ContMark) line_fill--;
        if (line_fill > 0) begin
          line_fill--;
          if (line_chars > 0) line_chars--;
          res.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (32'(idx) < line_fill) res.read_byte = line_bytes[idx];
      end
      default: begin
      end
    endcase
    res.byte_count = line_fill[7:0];
    res.char_count = line_chars[7:0];
    return res;
  endfunction

  // Report one differing field, printing only the first few
  task automatic check_field(input string field, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (want_v !== got_v) begin
      if (errors < 40)
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                 $time, field, want_v, got_v);
      errors++;
    end
  endtask

  // Score results, track the limit and predict each word taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_fill  = 0;
      line_chars = 0;
      byte_limit = LimitReset;
      due_results.delete();
      results_due_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          if (errors < 40)
            $display("%0t ns: result word with none expected, expected nothing, actual %b",
                     $time, {out_accepted_i, out_bytes_added_i, out_read_byte_i,
                             out_byte_count_i, out_char_count_i});
          errors++;
        end else begin
          oldest_due = due_results.pop_front();
          check_field("accepted", 8'(oldest_due.accepted), 8'(out_accepted_i));
          check_field("bytes_added", 8'(oldest_due.bytes_added), 8'(out_bytes_added_i));
          check_field("read_byte", oldest_due.read_byte, out_read_byte_i);
          check_field("byte_count", oldest_due.byte_count, out_byte_count_i);
          check_field("char_count", oldest_due.char_count, out_char_count_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) byte_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        due_results.push_back(edit_line(in_opcode_i, in_code_point_i, in_read_index_i));
      results_due_o <= due_results.size();
    end
  end

endmodule : utf8_line_edit_checker

// ----- bench/tb_utf8_line_edit_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_line_edit_buffer
// Bench top for the UTF-8 line edit buffer.
// ----------------------------------------------------------------------------
// Drives directed edits over the encoding boundaries, then random append,
// delete, read and unused-opcode words under a series of byte limits, with idle cycles on
// the sender and stalls on the receiver. Scoring is left to the checker; the
// top only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_utf8_line_edit_buffer;
  import ule_pkg::*;

  localparam int unsigned StoreBytes = 256;
  localparam logic [1:0]  OpUnused   = 2'd3;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        in_opcode_i = '0;
  logic [20:0]       in_code_point_i = '0;
  logic [7:0]        in_read_index_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              out_accepted_o;
  logic [2:0]        out_bytes_added_o;
  logic [7:0]        out_read_byte_o;
  logic [7:0]        out_byte_count_o;
  logic [7:0]        out_char_count_o;

  int unsigned fail_count;
  int unsigned results_due;

  // Idle rates of both sides, in percent
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // Tallies for the closing summary
  int unsigned n_append = 0;
  int unsigned n_delete = 0;
  int unsigned n_read = 0;
  int unsigned n_unused = 0;
  int unsigned n_limit = 0;

  utf8_line_edit_buffer #(
    .STORE_BYTES (StoreBytes)
  ) dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_opcode_i       (in_opcode_i),
    .in_code_point_i   (in_code_point_i),
    .in_read_index_i   (in_read_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_accepted_o    (out_accepted_o),
    .out_bytes_added_o (out_bytes_added_o),
    .out_read_byte_o   (out_read_byte_o),
    .out_byte_count_o  (out_byte_count_o),
    .out_char_count_o  (out_char_count_o)
  );

  utf8_line_edit_checker #(
    .STORE_BYTES (StoreBytes)
  ) u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_i        (in_stall_o),
    .in_opcode_i       (in_opcode_i),
    .in_code_point_i   (in_code_point_i),
    .in_read_index_i   (in_read_index_i),
    .out_valid_i       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_accepted_i    (out_accepted_o),
    .out_bytes_added_i (out_bytes_added_o),
    .out_read_byte_i   (out_read_byte_o),
    .out_byte_count_i  (out_byte_count_o),
    .out_char_count_i  (out_char_count_o),
    .fail_count_o      (fail_count),
    .results_due_o     (results_due)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one word, after an optional idle gap, and hold it until taken
  task automatic send_word(input logic [1:0] op, input logic [20:0] cp,
                           input logic [7:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    in_opcode_i     <= op;
    in_code_point_i <= cp;
    in_read_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_APPEND: n_append++;
      OP_DELETE: n_delete++;
      OP_READ:   n_read++;
      default:   n_unused++;
    endcase
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
  endtask

  // Write the byte limit; only called with the block drained
  task automatic write_limit(input logic [LimitW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_limit++;
  endtask

  // Random words: weights in percent, 3 for unused opcodes, reads take what is left
  task automatic send_random(input int unsigned count, input int unsigned append_w,
                             input int unsigned delete_w);
    logic [1:0]  op;
    logic [20:0] cp;
    logic [7:0]  idx;
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) op = OpUnused;
      else if (pick < 3 + append_w) op = OP_APPEND;
      else if (pick < 3 + append_w + delete_w) op = OP_DELETE;
      else op = OP_READ;
      case ($urandom_range(9))
        0:       cp = '0;
        1, 2:    cp = 21'($urandom_range(21'h00007F, 21'h000001));
        3, 4:    cp = 21'($urandom_range(21'h0007FF, 21'h000080));
        5, 6:    cp = 21'($urandom_range(21'h00FFFF, 21'h000800));
        7:       cp = 21'($urandom_range(21'h10FFFF, 21'h010000));
        default: cp = 21'($urandom_range(21'h1FFFFF, 21'h010000));
      endcase
      // bias reads towards the front where bytes usually sit
      idx = $urandom_range(1) ? 8'($urandom_range(31)) : 8'($urandom_range(255));
      send_word(op, cp, idx);
    end
  endtask

  // Main sequence
  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender light, receiver heavy
    send_idle_pct  = 7;
    recv_stall_pct = 55;

    // empty line: reads, delete on empty, zero code point
    send_word(OP_READ, 21'h0, 8'd0);
    send_word(OP_READ, 21'h1FFFFF, 8'd255);
    send_word(OP_DELETE, 21'h0, 8'd0);
    send_word(OP_APPEND, 21'h0, 8'd0);
    // both sides of every length boundary, surrogate and top of field
    send_word(OP_APPEND, 21'h000041, 8'd0);
    send_word(OP_APPEND, 21'h00007F, 8'd0);
    send_word(OP_APPEND, 21'h000080, 8'd0);
    send_word(OP_APPEND, 21'h0007FF, 8'd0);
    send_word(OP_APPEND, 21'h000800, 8'd0);
    send_word(OP_APPEND, 21'h00FFFF, 8'd0);
    send_word(OP_APPEND, 21'h010000, 8'd0);
    send_word(OP_APPEND, 21'h10FFFF, 8'd0);
    send_word(OP_APPEND, 21'h00D800, 8'd0);
    send_word(OP_APPEND, 21'h1FFFFF, 8'd0);
    send_word(OpUnused, 21'h1FFFFF, 8'd255);
    // read first, inner, last and one past the fill
    send_word(OP_READ, 21'h0, 8'd0);
    send_word(OP_READ, 21'h0, 8'd3);
    send_word(OP_READ, 21'h0, 8'd26);
    send_word(OP_READ, 21'h0, 8'd27);
    // delete four, three and four byte characters
    send_word(OP_DELETE, 21'h0, 8'd0);
    send_word(OP_DELETE, 21'h0, 8'd0);
    send_word(OP_DELETE, 21'h0, 8'd0);
    send_word(OP_READ, 21'h0, 8'd255);
    wait_drained();

    // smallest limit: nothing fits, not even the zero code point
    write_limit(9'd1);
    send_word(OP_APPEND, 21'h0, 8'd0);
    send_word(OP_APPEND, 21'h000041, 8'd0);
    send_random(15, 50, 30);
    wait_drained();

    write_limit(9'd2);
    send_random(20, 50, 30);
    wait_drained();

    // largest limit, appends heavy so the line fills up
    write_limit(9'd256);
    send_random(200, 70, 10);
    wait_drained();

    // receiver light, sender heavy
    send_idle_pct  = 55;
    recv_stall_pct = 7;

    // limit lowered below the fill
    write_limit(9'd12);
    send_random(60, 30, 45);
    wait_drained();

    write_limit(9'($urandom_range(64, 3)));
    send_random(180, 40, 40);
    wait_drained();

    // no idling at all
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    write_limit(9'd255);
    send_random(200, 55, 25);
    wait_drained();

    repeat (20) @(posedge clk_i);
    $display("Covered %0d words: %0d append, %0d delete, %0d read, %0d unused opcode",
             n_append + n_delete + n_read + n_unused, n_append, n_delete, n_read, n_unused);
    $display("Over %0d byte limit writes from 1 to 256, with three idle and stall patterns",
             n_limit);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout with %0d results still due", results_due);
    $display("*** FAILED ***");
    $finish;
  end

endmodule : tb_utf8_line_edit_buffer

// ----- sim.f -----
sv/ule_pkg.sv
sv/ule_byte_ram.sv
sv/ule_utf8_enc.sv
sv/ule_ctrl.sv
sv/utf8_line_edit_buffer.sv
sv/ule_checker.sv
bench/utf8_line_edit_checker.sv
bench/tb_utf8_line_edit_buffer.sv
